// ===== sv/mf_pkg.sv =====
// Shared types and constants of the four-channel median filter.
// Used by mf_window, mf_median and four_channel_median_filter; no dependencies.
`default_nettype none

package mf_pkg;

   localparam int CHANNELS           = 4;
   localparam int RAW_W              = 24;
   localparam int SAMPLE_W           = 23;
   localparam int WINDOW_LEN_DEFAULT = 5;
   localparam int WINDOW_LEN_MAX     = 32;

   localparam int REQ_TDATA_W = ((CHANNELS * RAW_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((CHANNELS * SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - CHANNELS * SAMPLE_W;

   typedef logic signed [RAW_W-1:0] raw_type;
   typedef logic [SAMPLE_W-1:0]     sample_type;

   localparam sample_type THRESHOLD_RESET = sample_type'(6);

endpackage

`default_nettype wire

// ===== sv/mf_window.sv =====
// Sliding sample window of one channel: clamps the reading and shifts it in.
// Depends on mf_pkg.
`default_nettype none

module mf_window #(
   parameter int WINDOW_LEN = mf_pkg::WINDOW_LEN_DEFAULT
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        shift_en,
   input  wire mf_pkg::raw_type                             raw_in,
   output      logic [WINDOW_LEN-1:0][mf_pkg::SAMPLE_W-1:0] window_out
);
   import mf_pkg::*;

   logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window_ff;
   logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window_in;
   sample_type                          sample;

   // A negative reading enters the window as zero.
   assign sample = raw_in[RAW_W-1] ? '0 : sample_type'(raw_in[SAMPLE_W-1:0]);

   // Entry zero is the oldest sample; the newest enters at the top.
   always_comb begin
      window_in = window_ff;
      if (shift_en) begin
         for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            window_in[i] = window_ff[i+1];
         end
         window_in[WINDOW_LEN-1] = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   assign window_out = window_ff;

endmodule

`default_nettype wire

// ===== sv/mf_median.sv =====
// Rank-based median of one window followed by the zero threshold.
// Purely combinational; depends on mf_pkg.
`default_nettype none

module mf_median #(
   parameter int WINDOW_LEN = mf_pkg::WINDOW_LEN_DEFAULT
) (
   input  wire logic [WINDOW_LEN-1:0][mf_pkg::SAMPLE_W-1:0] window_in,
   input  wire mf_pkg::sample_type                          threshold,
   output      mf_pkg::sample_type                          filtered
);
   import mf_pkg::*;

   localparam int RANK_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int MID_HI = WINDOW_LEN / 2;

   logic [RANK_W-1:0] rank [WINDOW_LEN];
   sample_type        mid_hi;
   sample_type        median;

   // Each sample's rank counts the samples that sort ahead of it. Ties are
   // broken by position, so the ranks form a permutation of 0..WINDOW_LEN-1.
   always_comb begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW_LEN; j++) begin
            if ((window_in[j] < window_in[i]) ||
                ((window_in[j] == window_in[i]) && (j < i))) begin
               rank[i] = rank[i] + RANK_W'(1);
            end
         end
      end
   end

   always_comb begin
      mid_hi = '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         if (rank[i] == RANK_W'(MID_HI)) begin
            mid_hi = mid_hi | window_in[i];
         end
      end
   end

   if ((WINDOW_LEN % 2) == 0) begin : g_even
      localparam int MID_LO = WINDOW_LEN / 2 - 1;

      sample_type          mid_lo;
      logic [SAMPLE_W:0]   mid_sum;

      always_comb begin
         mid_lo = '0;
         for (int i = 0; i < WINDOW_LEN; i++) begin
            if (rank[i] == RANK_W'(MID_LO)) begin
               mid_lo = mid_lo | window_in[i];
            end
         end
      end

      assign mid_sum = {1'b0, mid_hi} + {1'b0, mid_lo};
      assign median  = mid_sum[SAMPLE_W:1];
   end else begin : g_odd
      assign median = mid_hi;
   end

   assign filtered = (median < threshold) ? '0 : median;

endmodule

`default_nettype wire

// ===== sv/four_channel_median_filter.sv =====
// Top level of the four-channel sliding-window median filter.
// Depends on mf_pkg, mf_window and mf_median.
//
// Usage:
//   req_*  : one transaction carries a signed 24-bit reading per channel.
//   rsp_*  : one transaction per request carries the four filtered medians.
//   csr_*  : writes the 23-bit zero threshold; always ready. Write it only
//            while no request is in flight.
// Each accepted request shifts its clamped readings into the per-channel
// windows. The next cycle a rank-based median is formed from the window
// registers, thresholded, and loaded into the output register once that
// register is empty or draining. One request is taken every cycle while
// rsp_tready stays high; the throughput is set by the single median stage
// between the window registers and the output register.
// Reset clears all windows to zero, empties the pipeline and sets the
// threshold to 6. When the receiver stalls, the median stage holds its
// item and req_tready drops once both stages are full; nothing is lost.
`default_nettype none

module four_channel_median_filter #(
   parameter int WINDOW_LEN = mf_pkg::WINDOW_LEN_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: raw_ch0 [23:0], raw_ch1 [47:24], raw_ch2 [71:48], raw_ch3 [95:72]
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [mf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // rsp_tdata: filtered_ch0 [22:0], filtered_ch1 [45:23], filtered_ch2 [68:46],
   //            filtered_ch3 [91:69], zero padding [95:92]
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [mf_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire mf_pkg::sample_type               csr_data
);
   import mf_pkg::*;

   logic       req_accept;
   logic       stage_take;
   logic       stage_valid_ff;
   logic       stage_valid_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   sample_type threshold_ff;
   sample_type threshold_in;
   sample_type filtered     [CHANNELS];
   sample_type rsp_data_ff  [CHANNELS];

   assign csr_ready = 1'b1;

   // The median stage hands off when the output register is empty or draining.
   assign stage_take = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || stage_take;
   assign req_accept = req_tvalid && req_tready;

   assign stage_valid_in = req_accept || (stage_valid_ff && !stage_take);
   assign rsp_valid_in   = stage_take || (rsp_valid_ff && !rsp_tready);
   assign threshold_in   = (csr_valid && csr_ready) ? csr_data : threshold_ff;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window;

      mf_window #(
         .WINDOW_LEN(WINDOW_LEN)
      ) u_window (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (req_accept),
         .raw_in     (raw_type'(req_tdata[c*RAW_W +: RAW_W])),
         .window_out (window)
      );

      mf_median #(
         .WINDOW_LEN(WINDOW_LEN)
      ) u_median (
         .window_in (window),
         .threshold (threshold_ff),
         .filtered  (filtered[c])
      );

      always_ff @(posedge clock) begin
         if (stage_take) begin
            rsp_data_ff[c] <= filtered[c];
         end
      end

      assign rsp_tdata[c*SAMPLE_W +: SAMPLE_W] = rsp_data_ff[c];
   end

   assign rsp_tdata[RSP_TDATA_W-1 -: RSP_PAD_W] = '0;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         threshold_ff   <= THRESHOLD_RESET;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         threshold_ff   <= threshold_in;
      end
   end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench of four_channel_median_filter: directed corner cases, then
// random readings under three handshake-pressure phases, checked against a local predictor.
// Depends on mf_pkg and the four_channel_median_filter RTL.
`default_nettype none

module testbench;
   import mf_pkg::*;

   localparam int WIN_LEN       = WINDOW_LEN_DEFAULT;
   localparam int RSP_LATENCY   = 2;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 670;
   localparam sample_type THRESHOLD_MAX = '1;

   typedef logic [CHANNELS-1:0][RAW_W-1:0]    reading_row;
   typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] median_row;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // req_tdata: raw_ch0, raw_ch1, raw_ch2, raw_ch3, 24 bits each from bit 0 up
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // rsp_tdata: filtered_ch0..filtered_ch3, 23 bits each from bit 0 up, then zero padding
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   sample_type             csr_data;

   // Predictor state: per-channel windows, oldest sample first.
   sample_type window_samples [CHANNELS][WIN_LEN];
   sample_type zero_threshold_model;
   median_row  expected_medians [$];
   median_row  median_due;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int requests_sent = 0;
   int responses_checked = 0;
   int cycle_count = 0;

   four_channel_median_filter #(.WINDOW_LEN(WIN_LEN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_medians.size());
         $display("FAIL four_channel_median_filter");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic sample_type clamp_reading(input logic [RAW_W-1:0] raw);
      return raw[RAW_W-1] ? sample_type'(0) : raw[SAMPLE_W-1:0];
   endfunction

   // Shifts one reading per channel into the windows and returns the thresholded medians.
   function automatic median_row filter_readings(input reading_row readings);
      median_row         medians;
      sample_type        sorted [WIN_LEN];
      sample_type        key;
      sample_type        mid;
      logic [SAMPLE_W:0] pair_sum;
      int                j;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int i = 0; i < WIN_LEN - 1; i++)
            window_samples[ch][i] = window_samples[ch][i+1];
         window_samples[ch][WIN_LEN-1] = clamp_reading(readings[ch]);
         for (int i = 0; i < WIN_LEN; i++)
            sorted[i] = window_samples[ch][i];
         for (int i = 1; i < WIN_LEN; i++) begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key) begin
               sorted[j+1] = sorted[j];
               j--;
            end
            sorted[j+1] = key;
         end
         if (WIN_LEN % 2 == 0) begin
            pair_sum = {1'b0, sorted[WIN_LEN/2]} + {1'b0, sorted[WIN_LEN/2-1]};
            mid = pair_sum[SAMPLE_W:1];
         end else begin
            mid = sorted[WIN_LEN/2];
         end
         medians[ch] = (mid < zero_threshold_model) ? sample_type'(0) : mid;
      end
      return medians;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_checked++;
         if (expected_medians.size() == 0) begin
            report_mismatch("response transaction with no request outstanding");
         end else begin
            median_due = expected_medians.pop_front();
            for (int ch = 0; ch < CHANNELS; ch++) begin
               if (rsp_tdata[ch*SAMPLE_W +: SAMPLE_W] !== median_due[ch])
                  report_mismatch($sformatf("filtered_ch%0d got %0d, expected %0d", ch,
                                            rsp_tdata[ch*SAMPLE_W +: SAMPLE_W],
                                            median_due[ch]));
            end
            if (rsp_tdata[RSP_TDATA_W-1:CHANNELS*SAMPLE_W] !== '0)
               report_mismatch("nonzero padding in rsp_tdata");
         end
      end
   end

   // Entered and left at a falling edge; req_tvalid stays high for a back-to-back item.
   task automatic send_readings(input reading_row readings);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom, $urandom};
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= readings;
      do @(posedge clock); while (!req_tready);
      expected_medians.push_back(filter_readings(readings));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (expected_medians.size() != 0);
      repeat (RSP_LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_threshold(input sample_type value);
      drain_responses();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      zero_threshold_model = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic raw_type random_reading();
      case ($urandom_range(9))
         0, 1:    return raw_type'($urandom);
         2:       return {1'b1, 23'($urandom)};
         3:       return raw_type'(24'h7FFFFF);
         4:       return raw_type'($urandom_range(0, 15));
         5:       return raw_type'(0);
         default: return {1'b0, 23'($urandom)};
      endcase
   endfunction

   // Reset zeros still in the windows, clamping of negatives, and the default threshold.
   task automatic test_directed_corners();
      raw_type    corner_values [8];
      reading_row readings;
      corner_values = '{raw_type'(24'h7FFFFF), raw_type'(-8388608), raw_type'(-1),
                        raw_type'(0), raw_type'(1), raw_type'(5), raw_type'(6),
                        raw_type'(7)};
      for (int i = 0; i < 8; i++) begin
         for (int ch = 0; ch < CHANNELS; ch++)
            readings[ch] = corner_values[(i + 2*ch) % 8];
         send_readings(readings);
      end
   endtask

   // A threshold of zero forces nothing; the largest threshold passes only full-scale medians.
   task automatic test_threshold_extremes();
      reading_row readings;
      write_threshold(sample_type'(0));
      for (int i = 0; i < 4; i++) begin
         for (int ch = 0; ch < CHANNELS; ch++)
            readings[ch] = raw_type'((i + ch) % 4);
         send_readings(readings);
      end
      write_threshold(THRESHOLD_MAX);
      for (int i = 0; i < 7; i++) begin
         for (int ch = 0; ch < CHANNELS; ch++)
            readings[ch] = (i == 5 && ch % 2 == 0) ? raw_type'(-8388608) :
                           (i == 6) ? raw_type'(24'h7FFFFE) : raw_type'(24'h7FFFFF);
         send_readings(readings);
      end
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input sample_type threshold);
      reading_row readings;
      write_threshold(threshold);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Halfway through, hold the sender until the pipeline has drained.
         if (n == RANDOM_ITEMS / 2)
            drain_responses();
         for (int ch = 0; ch < CHANNELS; ch++)
            readings[ch] = random_reading();
         send_readings(readings);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      for (int ch = 0; ch < CHANNELS; ch++)
         for (int i = 0; i < WIN_LEN; i++)
            window_samples[ch][i] = '0;
      zero_threshold_model = THRESHOLD_RESET;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_corners();
      test_threshold_extremes();
      test_random_traffic(24, 53, sample_type'($urandom_range(0, 15)));
      test_random_traffic(53, 24, sample_type'($urandom_range(0, 8388607)));
      test_random_traffic(0, 0, THRESHOLD_RESET);
      drain_responses();

      $display("Checked %0d responses for %0d requests, window length %0d, in three",
               responses_checked, requests_sent, WIN_LEN);
      $display("stall phases with thresholds from 0 to full scale; %0d mismatches.",
               error_count);
      if (error_count == 0)
         $display("PASS four_channel_median_filter");
      else
         $display("FAIL four_channel_median_filter");
      $finish;
   end

endmodule

`default_nettype wire
